// ----- sv/pci_pkg.sv -----
package pci_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int CLOSE_LIMIT     = 4;
    localparam int DIST_W          = 11;
    localparam int COLOR_W         = 32;
    localparam int COUNT_W         = 9;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [0:0] REG_BPP = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- sv/pci_cell.sv -----
module pci_cell import pci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic [COLOR_W-1:0] i_data,
    output logic [COLOR_W-1:0] o_data
);

    logic [COLOR_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_data;
        end
    end

    assign o_data = r_entry;

endmodule

// ----- sv/pci_dist.sv -----
module pci_dist import pci_pkg::*; (
    input  logic [COLOR_W-1:0] i_a,
    input  logic [COLOR_W-1:0] i_b,
    output logic [DIST_W-1:0]  o_dist
);

    logic [7:0]        w_diff [4];
    logic [DIST_W-2:0] w_sum;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_a[8*k +: 8] > i_b[8*k +: 8]) begin
                w_diff[k] = i_a[8*k +: 8] - i_b[8*k +: 8];
            end else begin
                w_diff[k] = i_b[8*k +: 8] - i_a[8*k +: 8];
            end
        end
    end

    assign w_sum  = (10'(w_diff[0]) + 10'(w_diff[1])) + (10'(w_diff[2]) + 10'(w_diff[3]));
    assign o_dist = {w_sum, 1'b0};

endmodule

// ----- sv/palette_color_indexer_core.sv -----
// channel | direction | beat contents
// --------+-----------+-----------------------------------------------------------
// s_axis  | in        | tuser: command; tdata: argb_color, entry_index
// m_axis  | out       | tdata: color_index, newly_added, palette_modified, entry_count
// apb     | in/out    | reg 0 at byte 0: bits_per_pixel
//
// map and in-range set rotate the whole entry ring once through a single distance
// unit; the next beat is taken only after the scan and the done state.
// clear, unused codes and out-of-range set answer without a scan; the result is registered at accept.
// a synchronous reset zeroes all entries at once; no clearing pass is needed.
// a new beat is taken only while idle and the output register is free or draining.
module palette_color_indexer_core import pci_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] argb_color, [39:32] entry_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] color_index, [8] newly_added,
                                        // [9] palette_modified, [18:10] entry_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int                IDX_W   = $clog2(MAX_ENTRIES);
    localparam logic [IDX_W-1:0]   LAST    = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_ENTRIES);

    t_state r_state, n_state;

    logic [IDX_W-1:0]   r_step, n_step;
    logic               r_is_map, n_is_map;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [COUNT_W-1:0] r_tgt, n_tgt;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [DIST_W-1:0]  r_best_d, n_best_d;
    logic               r_add, n_add;
    logic [COUNT_W-1:0] r_used, n_used;
    logic               r_mod, n_mod;
    logic [3:0]         r_bpp, n_bpp;
    logic               r_m_valid, n_m_valid;
    logic [23:0]        r_m_data, n_m_data;

    logic [COLOR_W-1:0] w_cell_q [MAX_ENTRIES];
    logic [COLOR_W-1:0] w_tail_d;
    logic [DIST_W-1:0]  w_dist;
    logic [COUNT_W-1:0] w_cap_raw, w_cap;
    logic               w_shift, w_wr, w_at_tgt, w_in_scan, w_hit, w_app, w_set_wr;
    logic               w_out_free, w_fire, w_rot, w_done_load, w_cfg_wr;
    t_cmd               w_cmd;
    logic [COLOR_W-1:0] w_s_color;
    logic [7:0]         w_s_slot;
    logic [7:0]         w_res_idx;
    logic               w_res_add, w_imm;

    // ring of entries: cell 0 is the head, the tail takes the head back or a new color
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            if (gi == MAX_ENTRIES - 1) begin : g_tail
                pci_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_tail_d),
                    .o_data  (w_cell_q[gi])
                );
            end else begin : g_body
                pci_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_cell_q[gi+1]),
                    .o_data  (w_cell_q[gi])
                );
            end
        end
    endgenerate

    pci_dist u_dist (
        .i_a    (r_color),
        .i_b    (w_cell_q[0]),
        .o_dist (w_dist)
    );

    assign w_tail_d = w_wr ? r_color : w_cell_q[0];

    always_comb begin
        if (r_bpp >= 4'd8) begin
            w_cap_raw = 9'd256;
        end else begin
            w_cap_raw = 9'd1 << r_bpp[2:0];
        end
        w_cap = (w_cap_raw > CNT_MAX) ? CNT_MAX : w_cap_raw;
    end

    assign w_cmd     = t_cmd'(s_axis_tuser);
    assign w_s_color = s_axis_tdata[31:0];
    assign w_s_slot  = s_axis_tdata[39:32];
    assign w_fire    = s_axis_tvalid && s_axis_tready;
    assign w_rot     = (w_cmd == CMD_MAP) || ((w_cmd == CMD_SET) && (9'(w_s_slot) < w_cap));
    assign w_imm     = w_fire && !w_rot;

    // entry r_step sits at the head during this scan cycle
    assign w_at_tgt  = (COUNT_W'(r_step) == r_tgt);
    assign w_in_scan = (COUNT_W'(r_step) < r_tgt);
    assign w_hit     = (r_tgt != '0) && (r_best_d <= DIST_W'(CLOSE_LIMIT));
    assign w_app     = r_is_map && w_at_tgt && !w_hit && (r_used < w_cap);
    assign w_set_wr  = !r_is_map && w_at_tgt;
    assign w_wr      = w_shift && (w_app || w_set_wr);

    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2:2] == REG_BPP);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_fire && w_rot) n_state = ST_SCAN;
            ST_SCAN: if (r_step == LAST) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_shift       = 1'b0;
        w_done_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = w_out_free;
            ST_SCAN: w_shift = 1'b1;
            ST_DONE: w_done_load = w_out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_step    = r_step;
        n_is_map  = r_is_map;
        n_color   = r_color;
        n_tgt     = r_tgt;
        n_best    = r_best;
        n_best_d  = r_best_d;
        n_add     = r_add;
        n_used    = r_used;
        n_mod     = r_mod;
        n_bpp     = r_bpp;
        w_res_idx = 8'd0;
        w_res_add = 1'b0;

        if (w_cfg_wr) begin
            n_bpp  = pwdata[3:0];
            n_used = '0;
            n_mod  = 1'b0;
        end

        if (w_fire) begin
            n_step   = '0;
            n_color  = w_s_color;
            n_best   = '0;
            n_best_d = '1;
            n_add    = 1'b0;
            unique case (w_cmd)
                CMD_MAP: begin
                    n_is_map = 1'b1;
                    n_tgt    = r_used;
                end
                CMD_SET: begin
                    n_is_map  = 1'b0;
                    n_tgt     = 9'(w_s_slot);
                    w_res_idx = w_s_slot;
                end
                CMD_CLEAR: begin
                    n_used = '0;
                    n_mod  = 1'b0;
                end
                default: w_res_idx = 8'd0;
            endcase
        end

        if (w_shift) begin
            n_step = r_step + 1'b1;
            if (r_is_map && w_in_scan && (w_dist < r_best_d)) begin
                n_best   = r_step;
                n_best_d = w_dist;
            end
            if (w_app) begin
                n_used = r_used + 1'b1;
                n_mod  = 1'b1;
                n_add  = 1'b1;
            end
            if (w_set_wr) begin
                if (r_used <= r_tgt) begin
                    n_used = r_tgt + 1'b1;
                    n_mod  = 1'b1;
                end else if (w_cell_q[0] != r_color) begin
                    n_mod = 1'b1;
                end
            end
        end

        if (w_done_load) begin
            w_res_add = r_add;
            if (r_is_map && !r_add) begin
                w_res_idx = 8'(r_best);
            end else begin
                w_res_idx = r_tgt[7:0];
            end
        end

        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (w_imm || w_done_load) begin
            n_m_valid = 1'b1;
            n_m_data  = {5'b0, n_used, n_mod, w_res_add, w_res_idx};
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_used    <= '0;
            r_mod     <= 1'b0;
            r_bpp     <= 4'd8;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_used    <= n_used;
            r_mod     <= n_mod;
            r_bpp     <= n_bpp;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_map <= n_is_map;
        r_color  <= n_color;
        r_tgt    <= n_tgt;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_add    <= n_add;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign prdata        = (paddr[2:2] == REG_BPP) ? 32'(r_bpp) : 32'd0;
    assign pready        = 1'b1;

endmodule

// ----- sv/pci_chk.sv -----
module pci_chk import pci_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata
);

    // count never exceeds the ring size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[18:10] <= COUNT_W'(MAX_ENTRIES)))
        else $error("entry_count beyond capacity");

    // an appended color always leaves the palette modified
    a_add_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[8]) |-> i_m_tdata[9])
        else $error("newly_added without palette_modified");

    // no new beat is taken while a result is stalled
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |-> !i_s_tready)
        else $error("input ready while result stalled");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind palette_color_indexer_core pci_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_pci_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ----- verif/tb_top.sv -----
module tb_top;
    import pci_pkg::*;

    localparam logic [2:0] BPP_ADDR = {REG_BPP, 2'b00};
    localparam int PHASE_BEATS = 55;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [31:0] argb_color, [39:32] entry_index
    logic [1:0]  s_axis_tuser = CMD_NONE;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [7:0] color_index, [8] newly_added,
                                 // [9] palette_modified, [18:10] entry_count
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [8:0] entry_count;
        logic       palette_modified;
        logic       newly_added;
        logic [7:0] color_index;
    } t_answer;

    // mirror of the palette, predicts one answer per accepted command beat
    class palette_tracker;
        logic [31:0] entries [256];
        int unsigned used;
        bit          modified;
        int unsigned depth;
        t_answer     pending [$];
        int errors, n_map, n_added, n_near, n_full, n_set, n_clear, n_unused, n_depth;

        function new();
            foreach (entries[i]) entries[i] = '0;
            used = 0;
            modified = 1'b0;
            depth = 8;
        endfunction

        function int capacity();
            return (depth >= 8) ? 256 : (1 << depth);
        endfunction

        function int color_gap(logic [31:0] a, logic [31:0] b);
            int s;
            s = 0;
            for (int k = 0; k < 4; k++)
                s += (a[8*k +: 8] > b[8*k +: 8]) ? int'(a[8*k +: 8] - b[8*k +: 8])
                                                 : int'(b[8*k +: 8] - a[8*k +: 8]);
            return 2 * s;
        endfunction

        function void set_depth(logic [3:0] v);
            depth = 32'(v);
            used = 0;
            modified = 1'b0;
            n_depth++;
        endfunction

        function void note_command(t_cmd cmd, logic [31:0] color, logic [7:0] slot);
            t_answer a;
            int n, best, best_d, d, cap;
            a = '0;
            cap = capacity();
            case (cmd)
                CMD_MAP: begin
                    n_map++;
                    best = 0;
                    best_d = 1 << 30;
                    n = (used > cap) ? cap : used;
                    for (int i = 0; i < n; i++) begin
                        d = color_gap(color, entries[i]);
                        if (d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    if (n > 0 && best_d <= CLOSE_LIMIT) begin
                        a.color_index = 8'(best);
                        if (best_d > 0) n_near++;
                    end else if (used < cap) begin
                        entries[used] = color;
                        a.color_index = 8'(used);
                        a.newly_added = 1'b1;
                        used++;
                        modified = 1'b1;
                        n_added++;
                    end else begin
                        a.color_index = 8'(best);
                        n_full++;
                    end
                end
                CMD_SET: begin
                    n_set++;
                    a.color_index = slot;
                    if (slot < cap) begin
                        if (used <= slot) begin
                            used = slot + 1;
                            modified = 1'b1;
                        end else if (entries[slot] != color) begin
                            modified = 1'b1;
                        end
                        entries[slot] = color;
                    end
                end
                CMD_CLEAR: begin
                    n_clear++;
                    used = 0;
                    modified = 1'b0;
                end
                default: n_unused++;
            endcase
            a.palette_modified = modified;
            a.entry_count = 9'(used);
            pending.push_back(a);
        endfunction

        function void check_answer(logic [23:0] beat);
            t_answer got, want;
            got = t_answer'(beat[18:0]);
            if (pending.size() == 0) begin
                $error("result beat %h with no command outstanding", beat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.color_index !== want.color_index) begin
                $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
                errors++;
            end
            if (got.newly_added !== want.newly_added) begin
                $error("newly_added: expected %0d, got %0d", want.newly_added, got.newly_added);
                errors++;
            end
            if (got.palette_modified !== want.palette_modified) begin
                $error("palette_modified: expected %0d, got %0d",
                       want.palette_modified, got.palette_modified);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (beat[23:19] !== '0) begin
                $error("padding: expected 0, got %h", beat[23:19]);
                errors++;
            end
        endfunction
    endclass

    palette_tracker tracker = new();

    int depth_plan [9] = '{1, 0, 2, 15, 3, 9, 4, 8, 5};
    int burst_left = 0;
    logic [9:0] stall_tick = '0;

    palette_color_indexer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_command(t_cmd'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[39:32]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_answer(m_axis_tdata);
        if (i_rst_n && psel && penable && pwrite && pready && paddr == BPP_ADDR)
            tracker.set_depth(pwdata[3:0]);
    end

    // receiver backpressure: always ready, sparse stalls, periodic, coin flip
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0: m_axis_tready = 1'b1;
            2'd1: m_axis_tready = ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready = (stall_tick[2:0] < 3'd5);
            default: m_axis_tready = 1'($urandom_range(0, 1));
        endcase
    end

    initial begin
        #(12 * 1200000);
        $display("status: fail");
        $finish;
    end

    task automatic push_beat(t_cmd cmd, logic [31:0] color, logic [7:0] slot);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {slot, color};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_in_bursts(t_cmd cmd, logic [31:0] color, logic [7:0] slot);
        if (burst_left == 0) begin
            // occasional long gap so the sender also idles across a full scan
            pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                     : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push_beat(cmd, color, slot);
    endtask

    task automatic wait_for_answers();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_depth(logic [31:0] v);
        wait_for_answers();
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = BPP_ADDR;
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // mostly colors at or near existing entries so matches and near misses occur
    function automatic logic [31:0] pick_color();
        logic [31:0] c;
        int k, ch, step;
        k = $urandom_range(0, 9);
        if (tracker.used == 0 || k < 4) return $urandom;
        c = tracker.entries[$urandom_range(0, tracker.used - 1)];
        if (k < 6) return c;
        ch = $urandom_range(0, 3);
        step = (k < 9) ? $urandom_range(1, 2) : 3;
        if (c[8*ch +: 8] >= step) c[8*ch +: 8] = 8'(c[8*ch +: 8] - step);
        else c[8*ch +: 8] = 8'(c[8*ch +: 8] + step);
        return c;
    endfunction

    task automatic random_beat();
        int pick, cap;
        t_cmd cmd;
        logic [31:0] color;
        logic [7:0] slot;
        pick = $urandom_range(0, 99);
        cap = tracker.capacity();
        cmd = (pick < 62) ? CMD_MAP : (pick < 90) ? CMD_SET : (pick < 95) ? CMD_CLEAR : CMD_NONE;
        color = pick_color();
        if ($urandom_range(0, 3) != 0) slot = 8'($urandom_range(0, (cap > 255) ? 255 : cap));
        else slot = 8'($urandom);
        if (cmd == CMD_SET && $urandom_range(0, 2) == 0) color = tracker.entries[slot];
        send_in_bursts(cmd, color, slot);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset depth of 8: empty map, exact and near matches, sets, full palette
        push_beat(CMD_MAP, 32'h0000_0000, 8'h00);
        push_beat(CMD_MAP, 32'h0000_0000, 8'hFF);
        push_beat(CMD_MAP, 32'h0000_0001, 8'h00);
        push_beat(CMD_MAP, 32'h0000_0003, 8'h00);
        push_beat(CMD_MAP, 32'hFFFF_FFFF, 8'h00);
        push_beat(CMD_MAP, 32'hFEFF_FFFF, 8'h00);
        push_beat(CMD_SET, 32'h0000_0003, 8'h01);
        push_beat(CMD_SET, 32'h1234_5678, 8'h01);
        push_beat(CMD_SET, 32'hA5A5_A5A5, 8'h0A);
        push_beat(CMD_MAP, 32'h0000_0000, 8'h00);
        push_beat(CMD_MAP, 32'hA5A5_A5A6, 8'h00);
        push_beat(CMD_SET, 32'h5A5A_5A5A, 8'hFF);
        push_beat(CMD_MAP, 32'h8080_8080, 8'h00);
        push_beat(CMD_MAP, 32'h5A5A_5A5D, 8'h00);
        push_beat(CMD_NONE, 32'hFFFF_FFFF, 8'hFF);
        push_beat(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        push_beat(CMD_MAP, 32'h1234_5678, 8'h00);
        push_beat(CMD_SET, 32'h0000_0000, 8'h00);
        push_beat(CMD_SET, 32'hFFFF_FFFF, 8'h80);

        foreach (depth_plan[p]) begin
            write_depth(depth_plan[p]);
            repeat (PHASE_BEATS) random_beat();
        end

        wait_for_answers();
        repeat (MAX_ENTRIES_DEF + 8) @(posedge i_clk);
        $display("covered %0d maps (%0d appended, %0d near matches, %0d on a full palette),",
                 tracker.n_map, tracker.n_added, tracker.n_near, tracker.n_full);
        $display("%0d sets, %0d clears, %0d unused codes over %0d depth settings",
                 tracker.n_set, tracker.n_clear, tracker.n_unused, tracker.n_depth + 1);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
